FILE: design/assert_macros.svh
// assertion helpers included by the reply parser design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: design/rrsp_pkg.sv
package rrsp_pkg;

    typedef enum logic [3:0] {
        PH_TYPE   = 4'd0,
        PH_LINE   = 4'd1,
        PH_INT    = 4'd2,
        PH_BLEN   = 4'd3,
        PH_MCOUNT = 4'd4,
        PH_ELEN   = 4'd5,
        PH_ETYPE  = 4'd6,
        PH_BODY   = 4'd7,
        PH_TRAIL1 = 4'd8,
        PH_TRAIL2 = 4'd9,
        PH_SKIP   = 4'd10
    } phase_t;

    typedef logic [2:0] kind_t;
    typedef logic [2:0] event_t;

    localparam kind_t K_NONE   = 3'd0;
    localparam kind_t K_STATUS = 3'd1;
    localparam kind_t K_ERROR  = 3'd2;
    localparam kind_t K_INT    = 3'd3;
    localparam kind_t K_BULK   = 3'd4;
    localparam kind_t K_MULTI  = 3'd5;

    localparam event_t EV_PAYLOAD = 3'd0;
    localparam event_t EV_INT     = 3'd1;
    localparam event_t EV_NULL    = 3'd2;
    localparam event_t EV_END     = 3'd3;
    localparam event_t EV_EMPTY   = 3'd4;
    localparam event_t EV_FAULT   = 3'd5;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // characters dropped after the type byte of an error line
    localparam logic [2:0] ERR_SKIP = 3'd3;

endpackage

FILE: design/resp_reply_stream_parser.sv
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_ready   | data_byte
// out      | out_valid / out_ready | reply_kind, event_code, payload_byte,
//          |                      | integer_value, element_number, reply_done
//
// one byte per cycle while the output is not stalled: a byte sits in the input
// register, is parsed against the parser state and any event it yields lands
// in the output register.
// a stalled output holds the event; the input register still takes one byte.
// reset (rst_n low) puts the parser back to waiting for a type byte.
`include "assert_macros.svh"

module resp_reply_stream_parser
    import rrsp_pkg::*;
#(
    parameter int LENGTH_BITS = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         reply_kind,
    output logic [2:0]         event_code,
    output logic [7:0]         payload_byte,
    output logic signed [31:0] integer_value,
    output logic [31:0]        element_number,
    output logic               reply_done
);

    localparam logic [COUNT_BITS-1:0] CountOne = 1;
    localparam logic [LENGTH_BITS-1:0] LenOne  = 1;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // parser state
    phase_t                 phase_reg, phase_next;
    kind_t                  kind_reg, kind_next;
    logic [31:0]            acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic                   digits_reg, digits_next;
    logic [LENGTH_BITS-1:0] body_left_reg, body_left_next;
    logic [COUNT_BITS-1:0]  expected_reg, expected_next;
    logic [COUNT_BITS-1:0]  received_reg, received_next;
    logic [2:0]             line_pos_reg, line_pos_next;
    logic                   pending_cr_reg, pending_cr_next;

    // output stage
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    event_t      out_code_reg;
    logic [7:0]  out_byte_reg;
    logic [31:0] out_value_reg;
    logic [31:0] out_elem_reg;
    logic        out_done_reg;

    logic        step;

    // event of the current byte
    logic        ev_valid;
    kind_t       ev_kind;
    event_t      ev_code;
    logic [7:0]  ev_byte;
    logic [31:0] ev_value;
    logic [31:0] ev_elem;
    logic        ev_done;

    logic        do_fault, do_finish, do_num_end, do_elem_done;
    kind_t       fin_kind;
    event_t      fin_code;
    logic [31:0] fin_value;
    logic [31:0] fin_elem;
    event_t      elem_code;
    kind_t       fault_kind;
    logic [35:0] num_cand;
    logic        num_over;
    logic        null_val;
    logic [COUNT_BITS-1:0] received_inc;
    logic [7:0]  b;

    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;
    assign b        = in_byte_reg;

    // ten times the accumulator plus the digit, checked against the field limit
    assign num_cand = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {32'd0, b[3:0]};
    assign null_val = neg_reg && (acc_reg == 32'd1);
    assign received_inc = received_reg + CountOne;

    always_comb
    begin
        if (phase_reg == PH_INT)
        begin
            num_over = neg_reg ? (num_cand > 36'h0_8000_0000) : (num_cand > 36'h0_7FFF_FFFF);
        end
        else if (neg_reg)
        begin
            num_over = num_cand > 36'd1;
        end
        else if (phase_reg == PH_MCOUNT)
        begin
            num_over = num_cand[35:COUNT_BITS] != '0;
        end
        else
        begin
            num_over = num_cand[35:LENGTH_BITS] != '0;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        digits_next     = digits_reg;
        body_left_next  = body_left_reg;
        expected_next   = expected_reg;
        received_next   = received_reg;
        line_pos_next   = line_pos_reg;
        pending_cr_next = pending_cr_reg;

        ev_valid = 1'b0;
        ev_kind  = kind_reg;
        ev_code  = EV_PAYLOAD;
        ev_byte  = 8'd0;
        ev_value = 32'd0;
        ev_elem  = 32'd0;
        ev_done  = 1'b0;

        do_fault     = 1'b0;
        do_finish    = 1'b0;
        do_num_end   = 1'b0;
        do_elem_done = 1'b0;
        fin_kind     = kind_reg;
        fin_code     = EV_END;
        fin_value    = 32'd0;
        fin_elem     = 32'd0;
        elem_code    = EV_END;
        fault_kind   = kind_reg;

        unique case (phase_reg)
            PH_TYPE:
            begin
                kind_next       = K_NONE;
                acc_next        = 32'd0;
                neg_next        = 1'b0;
                digits_next     = 1'b0;
                body_left_next  = '0;
                expected_next   = '0;
                received_next   = '0;
                line_pos_next   = 3'd0;
                pending_cr_next = 1'b0;
                fault_kind      = K_NONE;
                unique case (b)
                    CH_PLUS:
                    begin
                        kind_next  = K_STATUS;
                        phase_next = PH_LINE;
                    end
                    CH_MINUS:
                    begin
                        kind_next  = K_ERROR;
                        phase_next = PH_LINE;
                    end
                    CH_COLON:
                    begin
                        kind_next  = K_INT;
                        phase_next = PH_INT;
                    end
                    CH_DOLLAR:
                    begin
                        kind_next  = K_BULK;
                        phase_next = PH_BLEN;
                    end
                    CH_STAR:
                    begin
                        kind_next  = K_MULTI;
                        phase_next = PH_MCOUNT;
                    end
                    default:
                    begin
                        do_fault = 1'b1;
                    end
                endcase
            end
            PH_LINE:
            begin
                if (pending_cr_reg)
                begin
                    if (b == CH_LF)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        do_fault = 1'b1;
                    end
                end
                else if (b == CH_CR)
                begin
                    pending_cr_next = 1'b1;
                end
                else if (b == CH_LF)
                begin
                    do_finish = 1'b1;
                end
                else if (kind_reg == K_ERROR && line_pos_reg < ERR_SKIP)
                begin
                    line_pos_next = line_pos_reg + 3'd1;
                end
                else
                begin
                    ev_valid = 1'b1;
                    ev_byte  = b;
                end
            end
            PH_INT, PH_BLEN, PH_MCOUNT, PH_ELEN:
            begin
                if (pending_cr_reg)
                begin
                    if (b == CH_LF)
                    begin
                        do_num_end = 1'b1;
                    end
                    else
                    begin
                        do_fault = 1'b1;
                    end
                end
                else if (b == CH_CR)
                begin
                    pending_cr_next = 1'b1;
                end
                else if (b == CH_LF)
                begin
                    do_num_end = 1'b1;
                end
                else if (b == CH_MINUS && !digits_reg && line_pos_reg == 3'd0)
                begin
                    neg_next      = 1'b1;
                    line_pos_next = 3'd1;
                end
                else if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    if (num_over)
                    begin
                        do_fault = 1'b1;
                    end
                    else
                    begin
                        acc_next      = num_cand[31:0];
                        digits_next   = 1'b1;
                        line_pos_next = 3'd1;
                    end
                end
                else
                begin
                    do_fault = 1'b1;
                end
            end
            PH_ETYPE:
            begin
                if (b != CH_DOLLAR)
                begin
                    do_fault = 1'b1;
                end
                else
                begin
                    acc_next        = 32'd0;
                    neg_next        = 1'b0;
                    digits_next     = 1'b0;
                    line_pos_next   = 3'd0;
                    pending_cr_next = 1'b0;
                    phase_next      = PH_ELEN;
                end
            end
            PH_BODY:
            begin
                body_left_next = body_left_reg - LenOne;
                if (body_left_reg == LenOne)
                begin
                    phase_next = PH_TRAIL1;
                end
                ev_valid = 1'b1;
                ev_byte  = b;
                ev_elem  = (kind_reg == K_MULTI) ? 32'(received_reg) : 32'd0;
            end
            PH_TRAIL1:
            begin
                phase_next = PH_TRAIL2;
            end
            PH_TRAIL2:
            begin
                if (kind_reg == K_MULTI)
                begin
                    do_elem_done = 1'b1;
                    elem_code    = EV_END;
                end
                else
                begin
                    do_finish = 1'b1;
                    fin_kind  = K_BULK;
                end
            end
            PH_SKIP:
            begin
                if (b == CH_LF)
                begin
                    phase_next = PH_TYPE;
                end
            end
            default:
            begin
                kind_next       = K_NONE;
                acc_next        = 32'd0;
                neg_next        = 1'b0;
                digits_next     = 1'b0;
                body_left_next  = '0;
                expected_next   = '0;
                received_next   = '0;
                line_pos_next   = 3'd0;
                pending_cr_next = 1'b0;
                phase_next      = PH_TYPE;
            end
        endcase

        // end of a number line
        if (do_num_end)
        begin
            if (!digits_reg)
            begin
                do_fault = 1'b1;
            end
            else if (phase_reg == PH_INT)
            begin
                do_finish = 1'b1;
                fin_kind  = K_INT;
                fin_code  = EV_INT;
                fin_value = neg_reg ? (32'd0 - acc_reg) : acc_reg;
            end
            else if (phase_reg == PH_MCOUNT)
            begin
                if (null_val)
                begin
                    do_finish = 1'b1;
                    fin_kind  = K_MULTI;
                    fin_code  = EV_NULL;
                end
                else if (acc_reg == 32'd0)
                begin
                    do_finish = 1'b1;
                    fin_kind  = K_MULTI;
                    fin_code  = EV_EMPTY;
                end
                else
                begin
                    expected_next   = acc_reg[COUNT_BITS-1:0];
                    received_next   = '0;
                    acc_next        = 32'd0;
                    neg_next        = 1'b0;
                    digits_next     = 1'b0;
                    line_pos_next   = 3'd0;
                    pending_cr_next = 1'b0;
                    phase_next      = PH_ETYPE;
                end
            end
            else if (null_val)
            begin
                if (phase_reg == PH_BLEN)
                begin
                    do_finish = 1'b1;
                    fin_kind  = K_BULK;
                    fin_code  = EV_NULL;
                end
                else
                begin
                    do_elem_done = 1'b1;
                    elem_code    = EV_NULL;
                end
            end
            else
            begin
                acc_next        = 32'd0;
                neg_next        = 1'b0;
                digits_next     = 1'b0;
                line_pos_next   = 3'd0;
                pending_cr_next = 1'b0;
                body_left_next  = acc_reg[LENGTH_BITS-1:0];
                phase_next      = (acc_reg == 32'd0) ? PH_TRAIL1 : PH_BODY;
            end
        end

        // one element of a multi-bulk reply complete
        if (do_elem_done)
        begin
            if (received_inc == expected_reg)
            begin
                do_finish = 1'b1;
                fin_kind  = K_MULTI;
                fin_code  = elem_code;
                fin_elem  = 32'(received_reg);
            end
            else
            begin
                received_next   = received_inc;
                acc_next        = 32'd0;
                neg_next        = 1'b0;
                digits_next     = 1'b0;
                line_pos_next   = 3'd0;
                pending_cr_next = 1'b0;
                phase_next      = PH_ETYPE;
                ev_valid        = 1'b1;
                ev_kind         = K_MULTI;
                ev_code         = elem_code;
                ev_elem         = 32'(received_reg);
            end
        end

        if (do_fault || do_finish)
        begin
            kind_next       = K_NONE;
            acc_next        = 32'd0;
            neg_next        = 1'b0;
            digits_next     = 1'b0;
            body_left_next  = '0;
            expected_next   = '0;
            received_next   = '0;
            line_pos_next   = 3'd0;
            pending_cr_next = 1'b0;
            ev_valid        = 1'b1;
            ev_done         = 1'b1;
            ev_byte         = 8'd0;
            if (do_fault)
            begin
                phase_next = (b == CH_LF) ? PH_TYPE : PH_SKIP;
                ev_kind    = fault_kind;
                ev_code    = EV_FAULT;
                ev_value   = 32'd0;
                ev_elem    = (fault_kind == K_MULTI) ? 32'(received_reg) : 32'd0;
            end
            else
            begin
                phase_next = PH_TYPE;
                ev_kind    = fin_kind;
                ev_code    = fin_code;
                ev_value   = fin_value;
                ev_elem    = fin_elem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_TYPE;
            kind_reg       <= K_NONE;
            acc_reg        <= 32'd0;
            neg_reg        <= 1'b0;
            digits_reg     <= 1'b0;
            body_left_reg  <= '0;
            expected_reg   <= '0;
            received_reg   <= '0;
            line_pos_reg   <= 3'd0;
            pending_cr_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step)
            begin
                out_valid_reg  <= ev_valid;
                phase_reg      <= phase_next;
                kind_reg       <= kind_next;
                acc_reg        <= acc_next;
                neg_reg        <= neg_next;
                digits_reg     <= digits_next;
                body_left_reg  <= body_left_next;
                expected_reg   <= expected_next;
                received_reg   <= received_next;
                line_pos_reg   <= line_pos_next;
                pending_cr_reg <= pending_cr_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= data_byte;
        end
        if (step)
        begin
            out_kind_reg  <= ev_kind;
            out_code_reg  <= ev_code;
            out_byte_reg  <= ev_byte;
            out_value_reg <= ev_value;
            out_elem_reg  <= ev_elem;
            out_done_reg  <= ev_done;
        end
    end

    assign out_valid      = out_valid_reg;
    assign reply_kind     = out_kind_reg;
    assign event_code     = out_code_reg;
    assign payload_byte   = out_byte_reg;
    assign integer_value  = out_value_reg;
    assign element_number = out_elem_reg;
    assign reply_done     = out_done_reg;

    `ASSERT_IMP(a_byte_only_payload, clk, rst_n,
        out_valid_reg && out_code_reg != EV_PAYLOAD, out_byte_reg == 8'd0,
        "payload byte set on a non-payload event")
    `ASSERT_IMP(a_elem_only_multi, clk, rst_n,
        out_valid_reg && out_elem_reg != 32'd0, out_kind_reg == K_MULTI,
        "element number outside a multi-bulk reply")
    `ASSERT_IMP(a_elem_count_bound, clk, rst_n,
        phase_reg == PH_ETYPE || phase_reg == PH_ELEN,
        kind_reg == K_MULTI && received_reg < expected_reg,
        "element wait with no element left")
    `ASSERT_NXT(a_done_restarts, clk, rst_n,
        step && ev_valid && ev_done && ev_code != EV_FAULT, phase_reg == PH_TYPE,
        "reply finished but parser not back at type byte")

endmodule
